// ----- hw/rtl/first_fit_heap_allocator_assert.svh -----
// assertion helpers for the allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// property sampled on the rising clock, off while reset is low
`define FFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ffha_pkg.sv -----
package ffha_pkg;

  localparam int unsigned OFS_W   = 23;
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned ST_W    = 3;

  localparam logic [SIZE_W-1:0] ARENA_BYTES  = 24'd8388608;
  localparam logic [SIZE_W-1:0] ALIGN_BYTES  = 24'd8;
  localparam logic [SIZE_W-1:0] HEADER_BYTES = 24'd24;
  localparam logic [CNT_W-1:0]  MAX_BLOCKS   = 7'd64;

  localparam logic [OFS_W-1:0] INIT_SIZE = OFS_W'(ARENA_BYTES - HEADER_BYTES);

  localparam logic [ST_W-1:0] STAT_OK     = 3'd0;
  localparam logic [ST_W-1:0] STAT_OOM    = 3'd1;
  localparam logic [ST_W-1:0] STAT_ZERO   = 3'd2;
  localparam logic [ST_W-1:0] STAT_BADOFS = 3'd3;
  localparam logic [ST_W-1:0] STAT_DOUBLE = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] size;
    logic             used;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SH_RD, S_SH_WR, S_WR_NEW, S_WR_CUR,
    S_NXT_RD, S_NXT_CHK, S_RM_RD, S_RM_WR, S_PRV_RD, S_PRV_CHK, S_DONE
  } state_e;

endpackage

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// channel   dir  tdata fields (lsb first)                   tuser
// s_axis    in   request_size[23:0], release_offset[46:24]  opcode
// m_axis    out  payload_offset[22:0], status[25:23]        -
//
// a request reads table entries one at a time through the single table read
// port while scanning, reads and rewrites each entry moved on a split or a merge,
// and adds setup and write back steps
// async active-low reset restores one free block spanning the arena
// input is taken only when idle; a waiting result does not block the next request
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // request_size, release_offset
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // payload_offset, status
);

  state_e state_q, state_d;
  tbl_req_t tbl_req;
  entry_t rd;

  logic             op_q, op_d;
  logic [SIZE_W-1:0] asize_q, asize_d;
  logic [OFS_W-1:0] offset_q, offset_d;
  logic [CNT_W-1:0] idx_q, idx_d, k_q, k_d, cnt_q, cnt_d;
  entry_t           cur_q, cur_d;
  logic             rm_prv_q, rm_prv_d;
  logic [OFS_W-1:0] res_ofs_q, res_ofs_d;
  logic [ST_W-1:0]  res_st_q, res_st_d;
  logic             out_valid_q;
  logic [OFS_W-1:0] out_ofs_q;
  logic [ST_W-1:0]  out_st_q;

  logic [SIZE_W-1:0] in_size;
  logic [OFS_W-1:0]  in_ofs;
  logic              in_bad;
  logic [SIZE_W:0]   rd_size_x;
  logic              hit, split_ok, out_free;

  ffha_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rd_data_o (rd)
  );

  assign in_size  = s_axis_tdata[23:0];
  assign in_ofs   = s_axis_tdata[46:24];
  assign in_bad   = (s_axis_tuser == OP_ALLOC) && (in_size == '0 || in_size > ARENA_BYTES);
  assign rd_size_x = {2'b00, rd.size};
  assign hit = (op_q == OP_ALLOC)
             ? (!rd.used && rd_size_x[SIZE_W-1:0] >= asize_q)
             : (({1'b0, rd.start} + HEADER_BYTES) == {1'b0, offset_q});
  assign split_ok = (rd_size_x >= ({1'b0, asize_q} + {1'b0, HEADER_BYTES + ALIGN_BYTES}))
                  && (cnt_q < MAX_BLOCKS);
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_st_q, out_ofs_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (s_axis_tvalid) state_d = in_bad ? S_DONE : S_SCAN_RD;
      S_SCAN_RD:  state_d = (idx_q == cnt_q) ? S_DONE : S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (!hit) state_d = S_SCAN_RD;
        else if (op_q == OP_ALLOC) state_d = split_ok ? S_SH_RD : S_WR_CUR;
        else state_d = rd.used ? S_NXT_RD : S_DONE;
      end
      S_SH_RD:    state_d = (k_q == idx_q + 7'd1) ? S_WR_NEW : S_SH_WR;
      S_SH_WR:    state_d = S_SH_RD;
      S_WR_NEW:   state_d = S_WR_CUR;
      S_WR_CUR:   state_d = S_DONE;
      S_NXT_RD:   state_d = (idx_q + 7'd1 < cnt_q) ? S_NXT_CHK : S_PRV_RD;
      S_NXT_CHK:  state_d = rd.used ? S_PRV_RD : S_RM_RD;
      S_RM_RD: begin
        if (k_q + 7'd1 == cnt_q) state_d = rm_prv_q ? S_PRV_RD : S_DONE;
        else state_d = S_RM_WR;
      end
      S_RM_WR:    state_d = S_RM_RD;
      S_PRV_RD:   state_d = (idx_q != '0) ? S_PRV_CHK : S_WR_CUR;
      S_PRV_CHK:  state_d = rd.used ? S_WR_CUR : S_RM_RD;
      S_DONE:     if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d      = op_q;
    asize_d   = asize_q;
    offset_d  = offset_q;
    idx_d     = idx_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    rm_prv_d  = rm_prv_q;
    res_ofs_d = res_ofs_q;
    res_st_d  = res_st_q;
    tbl_req   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d      = s_axis_tuser;
          asize_d   = (in_size + (ALIGN_BYTES - 24'd1)) & ~(ALIGN_BYTES - 24'd1);
          offset_d  = in_ofs;
          idx_d     = '0;
          res_ofs_d = '0;
          res_st_d  = (in_size == '0) ? STAT_ZERO : STAT_OOM;
        end
      end
      S_SCAN_RD: begin
        tbl_req.raddr = idx_q[IDX_W-1:0];
        res_st_d = (op_q == OP_ALLOC) ? STAT_OOM : STAT_BADOFS;
      end
      S_SCAN_CHK: begin
        if (!hit) begin
          idx_d = idx_q + 7'd1;
        end else if (op_q == OP_ALLOC) begin
          res_st_d  = STAT_OK;
          res_ofs_d = rd.start + OFS_W'(HEADER_BYTES);
          k_d       = cnt_q;
          cur_d     = rd;
          if (!split_ok) cur_d.used = 1'b1;
        end else begin
          res_st_d = rd.used ? STAT_OK : STAT_DOUBLE;
          cur_d    = rd;
          cur_d.used = 1'b0;
        end
      end
      S_SH_RD: tbl_req.raddr = IDX_W'(k_q - 7'd1);
      S_SH_WR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = k_q[IDX_W-1:0];
        tbl_req.wdata = rd;
        k_d = k_q - 7'd1;
      end
      S_WR_NEW: begin
        tbl_req.we          = 1'b1;
        tbl_req.waddr       = IDX_W'(idx_q + 7'd1);
        tbl_req.wdata.start = cur_q.start + OFS_W'(HEADER_BYTES) + OFS_W'(asize_q);
        tbl_req.wdata.size  = cur_q.size - OFS_W'(asize_q) - OFS_W'(HEADER_BYTES);
        tbl_req.wdata.used  = 1'b0;
        cnt_d      = cnt_q + 7'd1;
        cur_d.size = OFS_W'(asize_q);
        cur_d.used = 1'b1;
      end
      S_WR_CUR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = idx_q[IDX_W-1:0];
        tbl_req.wdata = cur_q;
      end
      S_NXT_RD: tbl_req.raddr = IDX_W'(idx_q + 7'd1);
      S_NXT_CHK: begin
        if (!rd.used) begin
          cur_d.size = cur_q.size + OFS_W'(HEADER_BYTES) + rd.size;
          k_d        = idx_q + 7'd1;
          rm_prv_d   = 1'b1;
        end
      end
      S_RM_RD: begin
        tbl_req.raddr = IDX_W'(k_q + 7'd1);
        if (k_q + 7'd1 == cnt_q) cnt_d = cnt_q - 7'd1;
      end
      S_RM_WR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = k_q[IDX_W-1:0];
        tbl_req.wdata = rd;
        k_d = k_q + 7'd1;
      end
      S_PRV_RD: tbl_req.raddr = IDX_W'(idx_q - 7'd1);
      S_PRV_CHK: begin
        if (!rd.used) begin
          // predecessor absorbs this block, then this entry is removed
          tbl_req.we         = 1'b1;
          tbl_req.waddr      = IDX_W'(idx_q - 7'd1);
          tbl_req.wdata      = rd;
          tbl_req.wdata.size = rd.size + OFS_W'(HEADER_BYTES) + cur_q.size;
          k_d      = idx_q;
          rm_prv_d = 1'b0;
        end
      end
      S_DONE: rm_prv_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 7'd1;
      rm_prv_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rm_prv_q <= rm_prv_d;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    asize_q   <= asize_d;
    offset_q  <= offset_d;
    idx_q     <= idx_d;
    k_q       <= k_d;
    cur_q     <= cur_d;
    res_ofs_q <= res_ofs_d;
    res_st_q  <= res_st_d;
    if (state_q == S_DONE && out_free) begin
      out_ofs_q <= (res_st_q == STAT_OK) ? res_ofs_q : '0;
      out_st_q  <= res_st_q;
    end
  end

endmodule

// ----- hw/rtl/ffha_table.sv -----
module ffha_table
  import ffha_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tbl_req_t req_i,
  output entry_t   rd_data_o
);

  entry_t mem [2**IDX_W];
  entry_t rd_q;
  logic   e0_written_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem[req_i.raddr];
  end

  // entry 0 holds the whole-arena block until first written
  logic e0_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_written_q <= 1'b0;
      e0_rd_q      <= 1'b0;
    end else begin
      e0_rd_q <= (req_i.raddr == '0) && !e0_written_q;
      if (req_i.we && req_i.waddr == '0) begin
        e0_written_q <= 1'b1;
      end
    end
  end

  always_comb begin
    if (e0_rd_q) begin
      rd_data_o = '{start: '0, size: INIT_SIZE, used: 1'b0};
    end else begin
      rd_data_o = rd_q;
    end
  end

endmodule

// ----- hw/rtl/ffha_checker.sv -----
module ffha_checker
  import ffha_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

`include "first_fit_heap_allocator_assert.svh"

  `FFHA_ASSERT(a_err_zero_ofs, !m_axis_tvalid || m_axis_tdata[25:23] == STAT_OK || m_axis_tdata[22:0] == '0, "non-ok result carries an offset")
  `FFHA_ASSERT(a_status_range, !m_axis_tvalid || m_axis_tdata[25:23] <= STAT_DOUBLE, "status code out of range")
  `FFHA_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after a request")
  `FFHA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

// ----- tb/testbench.sv -----
module testbench;
  import ffha_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam longint unsigned CYCLE_LIMIT = 64'd8000000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // request_size[23:0], release_offset[46:24]
  logic        s_axis_tuser = 1'b0;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // payload_offset[22:0], status[25:23]

  first_fit_heap_allocator dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  typedef struct {
    logic [OFS_W-1:0] ofs;
    logic [ST_W-1:0]  st;
  } reply_t;

  typedef struct {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [OFS_W-1:0]  ofs;
    bit                typed;
    logic [OFS_W-1:0]  want_ofs;
    logic [ST_W-1:0]   want_st;
  } row_t;

  reply_t pending_replies[$];
  int     errors = 0;
  int     phase = 0;       // 0: sender 27 / receiver 65, 1: swapped, 2: no idling after the receiver hold-off
  int     hold_left = 0;
  longint unsigned cycles = 0;

  // shadow of the block table
  longint unsigned heap_start[64];
  longint unsigned heap_bytes[64];
  bit              heap_used[64];
  int              heap_count;

  int unsigned live_q[$];
  int unsigned freed_q[$];

  task automatic heap_insert(input int pos);
    for (int k = heap_count; k > pos; k--) begin
      heap_start[k] = heap_start[k-1];
      heap_bytes[k] = heap_bytes[k-1];
      heap_used[k] = heap_used[k-1];
    end
    heap_count++;
  endtask

  task automatic heap_remove(input int pos);
    for (int k = pos; k + 1 < heap_count; k++) begin
      heap_start[k] = heap_start[k+1];
      heap_bytes[k] = heap_bytes[k+1];
      heap_used[k] = heap_used[k+1];
    end
    heap_count--;
    heap_start[heap_count] = 0;
    heap_bytes[heap_count] = 0;
    heap_used[heap_count] = 0;
  endtask

  task automatic heap_apply(input logic op, input logic [SIZE_W-1:0] size,
                            input logic [OFS_W-1:0] rel, output reply_t r);
    longint unsigned asize;
    int i;
    r.ofs = '0;
    r.st = STAT_OOM;
    if (op == OP_ALLOC) begin
      if (size == 0) begin
        r.st = STAT_ZERO;
      end else if (size <= ARENA_BYTES) begin
        asize = ((longint'(size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        for (i = 0; i < heap_count; i++) begin
          if (heap_used[i] || heap_bytes[i] < asize) continue;
          if (heap_bytes[i] >= asize + HEADER_BYTES + ALIGN_BYTES &&
              heap_count < MAX_BLOCKS) begin
            heap_insert(i + 1);
            heap_start[i+1] = heap_start[i] + HEADER_BYTES + asize;
            heap_bytes[i+1] = heap_bytes[i] - asize - HEADER_BYTES;
            heap_used[i+1] = 0;
            heap_bytes[i] = asize;
          end
          heap_used[i] = 1;
          r.ofs = OFS_W'(heap_start[i] + HEADER_BYTES);
          r.st = STAT_OK;
          break;
        end
      end
    end else begin
      for (i = 0; i < heap_count; i++)
        if (heap_start[i] + HEADER_BYTES == longint'(rel)) break;
      if (i >= heap_count) begin
        r.st = STAT_BADOFS;
      end else if (!heap_used[i]) begin
        r.st = STAT_DOUBLE;
      end else begin
        r.st = STAT_OK;
        heap_used[i] = 0;
        if (i + 1 < heap_count && !heap_used[i+1]) begin
          heap_bytes[i] += HEADER_BYTES + heap_bytes[i+1];
          heap_remove(i + 1);
        end
        if (i > 0 && !heap_used[i-1]) begin
          heap_bytes[i-1] += HEADER_BYTES + heap_bytes[i];
          heap_remove(i);
        end
      end
    end
    // track live payloads for well-formed frees
    if (r.st == STAT_OK) begin
      if (op == OP_ALLOC) begin
        live_q.push_back(32'(r.ofs));
      end else begin
        foreach (live_q[k])
          if (live_q[k] == rel) begin
            live_q.delete(k);
            break;
          end
        freed_q.push_back(32'(rel));
        if (freed_q.size() > 8) void'(freed_q.pop_front());
      end
    end
  endtask

  // assumes the caller sits at a rising edge
  task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                              input logic [OFS_W-1:0] rel, input bit typed,
                              input reply_t typed_reply);
    bit hit;
    reply_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {1'b0, rel, size};
    do begin
      @(negedge clk_i);
      hit = s_axis_tready;
      @(posedge clk_i);
    end while (!hit);
    heap_apply(op, size, rel, r);
    pending_replies.push_back(typed ? typed_reply : r);
    if ((phase == 0 && $urandom_range(99) < 27) || (phase == 1 && $urandom_range(99) < 65)) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_request();
    int unsigned pick;
    logic op;
    logic [SIZE_W-1:0] size;
    logic [OFS_W-1:0] rel;
    reply_t none;
    none.ofs = '0;
    none.st = STAT_OK;
    pick = $urandom_range(99);
    op = OP_ALLOC;
    size = SIZE_W'($urandom);
    rel = OFS_W'($urandom);
    if (pick < 5) begin
      op = 1'($urandom_range(1));  // noise
    end else if (pick < 7) begin
      size = '0;
    end else if (pick < 9 && freed_q.size() != 0) begin
      op = OP_FREE;
      rel = OFS_W'(freed_q[$urandom_range(freed_q.size() - 1)]);
    end else if (pick < 11) begin
      op = OP_FREE;
      rel = (live_q.size() != 0) ? OFS_W'(live_q[0] + 8) : OFS_W'($urandom_range(1, 23));
    end else if (live_q.size() == 0 ||
                 $urandom_range(99) < ((live_q.size() < 70) ? 60 : 35)) begin
      pick = $urandom_range(99);
      if (pick < 80) size = SIZE_W'($urandom_range(1, 256));
      else if (pick < 95) size = SIZE_W'($urandom_range(1, 65536));
      else size = SIZE_W'($urandom_range(1, 2097152));
    end else begin
      op = OP_FREE;
      rel = OFS_W'(live_q[$urandom_range(live_q.size() - 1)]);
    end
    send_request(op, size, rel, 1'b0, none);
  endtask

  // receiver side, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (phase == 0) begin
      m_axis_tready <= ($urandom_range(99) >= 65);
    end else if (phase == 1) begin
      m_axis_tready <= ($urandom_range(99) >= 27);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result ofs=%0d status=%0d", $time,
                 m_axis_tdata[22:0], m_axis_tdata[25:23]);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata[22:0] !== want.ofs) begin
          $display("%0t: payload_offset expected %0d got %0d", $time, want.ofs,
                   m_axis_tdata[22:0]);
          errors++;
        end
        if (m_axis_tdata[25:23] !== want.st) begin
          $display("%0t: status expected %0d got %0d", $time, want.st, m_axis_tdata[25:23]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  row_t directed[$];

  function automatic row_t mk(input logic op, input logic [SIZE_W-1:0] size,
                              input logic [OFS_W-1:0] rel, input bit typed,
                              input logic [OFS_W-1:0] wo, input logic [ST_W-1:0] ws);
    row_t r;
    r.op = op; r.size = size; r.ofs = rel; r.typed = typed;
    r.want_ofs = wo; r.want_st = ws;
    return r;
  endfunction

  initial begin
    reply_t tr;
    heap_start = '{default: 0};
    heap_bytes = '{default: 0};
    heap_used = '{default: 0};
    heap_bytes[0] = ARENA_BYTES - HEADER_BYTES;
    heap_count = 1;

    directed.push_back(mk(OP_ALLOC, 24'd0, 23'd0, 1'b1, 23'd0, STAT_ZERO));
    directed.push_back(mk(OP_ALLOC, 24'd8388609, 23'h7FFFFF, 1'b1, 23'd0, STAT_OOM));
    directed.push_back(mk(OP_ALLOC, 24'hFFFFFF, 23'd0, 1'b1, 23'd0, STAT_OOM));
    directed.push_back(mk(OP_ALLOC, 24'd8388608, 23'd0, 1'b1, 23'd0, STAT_OOM));
    directed.push_back(mk(OP_FREE, 24'hFFFFFF, 23'd0, 1'b1, 23'd0, STAT_BADOFS));
    directed.push_back(mk(OP_FREE, 24'd0, 23'h7FFFFF, 1'b1, 23'd0, STAT_BADOFS));
    directed.push_back(mk(OP_ALLOC, 24'd1, 23'd0, 1'b1, 23'd24, STAT_OK));
    directed.push_back(mk(OP_FREE, 24'd0, 23'd24, 1'b1, 23'd0, STAT_OK));
    directed.push_back(mk(OP_FREE, 24'd0, 23'd24, 1'b1, 23'd0, STAT_DOUBLE));
    directed.push_back(mk(OP_ALLOC, 24'd8388584, 23'd0, 1'b1, 23'd24, STAT_OK));
    directed.push_back(mk(OP_ALLOC, 24'd8, 23'd0, 1'b1, 23'd0, STAT_OOM));
    directed.push_back(mk(OP_FREE, 24'd0, 23'd24, 1'b1, 23'd0, STAT_OK));
    directed.push_back(mk(OP_ALLOC, 24'd16, 23'd0, 1'b1, 23'd24, STAT_OK));
    directed.push_back(mk(OP_ALLOC, 24'd8, 23'd0, 1'b1, 23'd64, STAT_OK));
    directed.push_back(mk(OP_ALLOC, 24'd7, 23'd0, 1'b0, 23'd0, STAT_OK));
    directed.push_back(mk(OP_FREE, 24'd0, 23'd64, 1'b0, 23'd0, STAT_OK));
    directed.push_back(mk(OP_FREE, 24'd0, 23'd24, 1'b0, 23'd0, STAT_OK));
    directed.push_back(mk(OP_FREE, 24'd0, 23'd96, 1'b0, 23'd0, STAT_OK));
    directed.push_back(mk(OP_ALLOC, 24'd8388560, 23'd0, 1'b0, 23'd0, STAT_OK));
    directed.push_back(mk(OP_ALLOC, 24'd8, 23'd0, 1'b0, 23'd0, STAT_OK));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      tr.ofs = directed[i].want_ofs;
      tr.st = directed[i].want_st;
      send_request(directed[i].op, directed[i].size, directed[i].ofs, directed[i].typed, tr);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
    // clear the directed leftovers so random runs start from a known heap
    while (live_q.size() != 0) begin
      tr.ofs = '0;
      tr.st = STAT_OK;
      send_request(OP_FREE, '0, OFS_W'(live_q[0]), 1'b0, tr);
    end

    for (int p = 0; p < 3; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      @(posedge clk_i);
      phase <= p;
      @(posedge clk_i);
      if (p == 2) hold_left <= HOLD_CYCLES;  // receiver stalls while requests keep coming
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) random_request();
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
